FILE: rtl/pelst_pkg.sv
// Package for the per-entry latency statistics table.
// Port widths, command codes, defaults and controller states; no dependencies.
`timescale 1ns / 1ps

package pelst_pkg;

  // Port widths, fixed by the interface
  localparam int CMD_W       = 2;
  localparam int IDX_W       = 6;
  localparam int TICK_PORT_W = 32;
  localparam int CNT_W       = 32;
  localparam int SUM_PORT_W  = 48;

  // Parameter defaults
  localparam int NUM_ENTRIES_DEF = 64;
  localparam int TICK_WIDTH_DEF  = 32;
  localparam int SUM_WIDTH_DEF   = 48;

  // Trimmed mean kicks in above this many samples and drops min and max
  localparam int TRIM_THRESHOLD = 10;
  localparam int TRIM_DROP      = 2;

  typedef logic [CMD_W-1:0] cmd_t;
  localparam cmd_t CMD_RECORD = 2'd0;
  localparam cmd_t CMD_CLEAR  = 2'd2;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOK,
    ST_PREP,
    ST_DIV,
    ST_DONE,
    ST_CLEAR
  } state_t;

endpackage

FILE: rtl/pelst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pelst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/pelst_div.sv
// Restoring divider, one quotient bit per cycle.
// No dependencies; divisor must be nonzero.
`timescale 1ns / 1ps

module pelst_div #(
  parameter int DW = 48,
  parameter int VW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [VW-1:0] rem;
  logic [DW-1:0] quo;
  logic [VW-1:0] dvs;
  logic [CW-1:0] steps;
  logic [VW:0]   rem_sh;
  logic          ge;
  logic [VW-1:0] rem_next;

  assign rem_sh   = {rem, quo[DW-1]};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign rem_next = ge ? VW'(rem_sh - {1'b0, dvs}) : VW'(rem_sh);
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy  <= 1'b1;
        steps <= CW'(DW);
      end else if (busy) begin
        steps <= steps - CW'(1);
        if (steps == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[DW-2:0], ge};
    end
  end

endmodule

FILE: rtl/per_entry_latency_stats_table.sv
// Record/read: the result strobe follows the lookup, the entry update and the bit-serial
// mean divide; an empty entry skips the divide. A new request is taken only when idle.
// Clear-all sweeps the entry RAM, one entry a cycle, then strobes done.
// Reset (rst, synchronous) runs the same sweep with busy high.
// Results are shown for one cycle on done; the receiver cannot stall.
// Depends on pelst_pkg, pelst_ram, pelst_div.
`timescale 1ns / 1ps

module per_entry_latency_stats_table #(
  parameter int NUM_ENTRIES = pelst_pkg::NUM_ENTRIES_DEF,
  parameter int TICK_WIDTH  = pelst_pkg::TICK_WIDTH_DEF,
  parameter int SUM_WIDTH   = pelst_pkg::SUM_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [pelst_pkg::CMD_W-1:0]       command,
  input  logic [pelst_pkg::IDX_W-1:0]       entry_index,
  input  logic [pelst_pkg::TICK_PORT_W-1:0] sample_ticks,
  output logic                             done,
  output logic [pelst_pkg::IDX_W-1:0]       entry_echo,
  output logic [pelst_pkg::CNT_W-1:0]       call_count,
  output logic [pelst_pkg::TICK_PORT_W-1:0] shortest_ticks,
  output logic [pelst_pkg::TICK_PORT_W-1:0] longest_ticks,
  output logic [pelst_pkg::SUM_PORT_W-1:0]  sum_ticks,
  output logic [pelst_pkg::TICK_PORT_W-1:0] mean_ticks,
  output logic                             has_samples
);

  import pelst_pkg::*;

  localparam int AW     = $clog2(NUM_ENTRIES);
  localparam int WORD_W = 1 + CNT_W + 2 * TICK_WIDTH + SUM_WIDTH;
  localparam int MAX_LO = SUM_WIDTH;
  localparam int MIN_LO = SUM_WIDTH + TICK_WIDTH;
  localparam int CNT_LO = SUM_WIDTH + 2 * TICK_WIDTH;
  localparam int VLD_B  = WORD_W - 1;
  // widths for the saturating sum and the trimmed total
  localparam int ADD_W  = ((SUM_WIDTH > TICK_WIDTH) ? SUM_WIDTH : TICK_WIDTH) + 1;
  localparam int EDG_W  = (SUM_WIDTH > TICK_WIDTH + 1) ? SUM_WIDTH : TICK_WIDTH + 1;
  localparam logic [TICK_WIDTH-1:0] TICK_ONES  = '1;
  localparam logic [SUM_WIDTH-1:0]  SUM_ONES   = '1;
  localparam logic [CNT_W-1:0]      CNT_ONES   = '1;
  localparam logic [AW-1:0]         SWEEP_LAST = AW'(NUM_ENTRIES - 1);

  state_t state, state_next;
  logic [AW-1:0] sweep;

  // request registers
  cmd_t                  cmd_r;
  logic [IDX_W-1:0]      idx_r;
  logic [TICK_WIDTH-1:0] ticks_r;
  logic                  in_rng_r;
  logic                  in_rng;

  // entry as reported
  logic [CNT_W-1:0]      e_cnt;
  logic [TICK_WIDTH-1:0] e_min;
  logic [TICK_WIDTH-1:0] e_max;
  logic [SUM_WIDTH-1:0]  e_sum;
  logic                  e_has;
  logic [TICK_WIDTH-1:0] mean_r;

  // RAM
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  // lookup / update
  logic                  cur_vld;
  logic [CNT_W-1:0]      b_cnt, u_cnt;
  logic [TICK_WIDTH-1:0] b_min, b_max, u_min, u_max;
  logic [SUM_WIDTH-1:0]  b_sum, u_sum;
  logic [ADD_W-1:0]      add_tot;
  logic                  do_rec;

  // mean setup
  logic [TICK_WIDTH:0]   edge_sum;
  logic [SUM_WIDTH-1:0]  dvd;
  logic [CNT_W-1:0]      dvs;
  logic                  trim;

  // divider
  logic                  div_go, div_busy, div_done;
  logic [SUM_WIDTH-1:0]  div_quo;

  assign in_rng = 32'(entry_index) < 32'(NUM_ENTRIES);

  pelst_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_ENTRIES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (AW'(entry_index)),
    .rdata (ram_rdata)
  );

  pelst_div #(
    .DW (SUM_WIDTH),
    .VW (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (dvd),
    .divisor  (dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // read-modify-write of the looked-up entry
  always_comb begin
    cur_vld = ram_rdata[VLD_B] && in_rng_r;
    b_cnt   = cur_vld ? ram_rdata[CNT_LO +: CNT_W]      : '0;
    b_min   = cur_vld ? ram_rdata[MIN_LO +: TICK_WIDTH] : TICK_ONES;
    b_max   = cur_vld ? ram_rdata[MAX_LO +: TICK_WIDTH] : '0;
    b_sum   = cur_vld ? ram_rdata[0 +: SUM_WIDTH]       : '0;
    do_rec  = (cmd_r == CMD_RECORD) && in_rng_r;
    u_cnt   = (b_cnt == CNT_ONES) ? b_cnt : b_cnt + CNT_W'(1);
    add_tot = ADD_W'(b_sum) + ADD_W'(ticks_r);
    u_sum   = (add_tot > ADD_W'(SUM_ONES)) ? SUM_ONES : SUM_WIDTH'(add_tot);
    u_min   = (ticks_r < b_min) ? ticks_r : b_min;
    u_max   = (ticks_r > b_max) ? ticks_r : b_max;
  end

  // divider operands; a saturated sum can fall below min + max
  always_comb begin
    edge_sum = {1'b0, e_min} + {1'b0, e_max};
    trim     = e_cnt > CNT_W'(TRIM_THRESHOLD);
    if (trim) begin
      dvd = (EDG_W'(e_sum) >= EDG_W'(edge_sum)) ?
            SUM_WIDTH'(EDG_W'(e_sum) - EDG_W'(edge_sum)) : '0;
      dvs = e_cnt - CNT_W'(TRIM_DROP);
    end else begin
      dvd = e_sum;
      dvs = e_cnt;
    end
  end

  assign e_has = e_cnt != '0;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT:  if (sweep == SWEEP_LAST) state_next = ST_IDLE;
      ST_IDLE: begin
        if (start) state_next = (command == CMD_CLEAR) ? ST_CLEAR : ST_LOOK;
      end
      ST_LOOK:  state_next = ST_PREP;
      ST_PREP:  state_next = e_has ? ST_DIV : ST_DONE;
      ST_DIV:   if (div_done) state_next = ST_DONE;
      ST_DONE:  state_next = ST_IDLE;
      ST_CLEAR: if (sweep == SWEEP_LAST) state_next = ST_PREP;
      default:  state_next = ST_INIT;
    endcase
  end

  // controller outputs
  always_comb begin
    busy      = 1'b1;
    done      = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = sweep;
    ram_wdata = '0;
    div_go    = 1'b0;
    case (state)
      ST_INIT, ST_CLEAR: ram_we = 1'b1;
      ST_IDLE: begin
        busy   = 1'b0;
        ram_re = start;
      end
      ST_LOOK: begin
        ram_we    = do_rec;
        ram_waddr = AW'(idx_r);
        ram_wdata = {1'b1, u_cnt, u_min, u_max, u_sum};
      end
      ST_PREP:  div_go = e_has;
      ST_DONE:  done = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      sweep <= '0;
    end else begin
      state <= state_next;
      if (state == ST_INIT || state == ST_CLEAR) begin
        sweep <= (sweep == SWEEP_LAST) ? '0 : sweep + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      cmd_r    <= command;
      idx_r    <= entry_index;
      ticks_r  <= TICK_WIDTH'(sample_ticks);
      in_rng_r <= in_rng;
      e_cnt    <= '0;
      e_min    <= TICK_ONES;
      e_max    <= '0;
      e_sum    <= '0;
    end
    if (state == ST_LOOK) begin
      e_cnt <= do_rec ? u_cnt : b_cnt;
      e_min <= do_rec ? u_min : b_min;
      e_max <= do_rec ? u_max : b_max;
      e_sum <= do_rec ? u_sum : b_sum;
    end
    if (state == ST_PREP && !e_has) begin
      mean_r <= '0;
    end
    if (state == ST_DIV && div_done) begin
      mean_r <= (div_quo > SUM_WIDTH'(TICK_ONES)) ? TICK_ONES : TICK_WIDTH'(div_quo);
    end
  end

  assign entry_echo     = idx_r;
  assign call_count     = e_cnt;
  assign shortest_ticks = TICK_PORT_W'(e_min);
  assign longest_ticks  = TICK_PORT_W'(e_max);
  assign sum_ticks      = SUM_PORT_W'(e_sum);
  assign mean_ticks     = TICK_PORT_W'(mean_r);
  assign has_samples    = e_has;

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held longer than one cycle");

  a_we_states: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_LOOK || state == ST_CLEAR || state == ST_INIT))
    else $error("entry RAM written outside sweep or update");

  a_div_idle: assert property (@(posedge clk) disable iff (rst) div_go |-> !div_busy)
    else $error("divider restarted while busy");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    (done && e_has) |-> (e_min <= e_max))
    else $error("reported min above max");

  a_empty_mean: assert property (@(posedge clk) disable iff (rst)
    (done && !e_has) |-> (mean_r == '0 && e_sum == '0))
    else $error("empty entry reports nonzero mean or sum");

endmodule
